/* rtl/cafd_pkg.sv */
`timescale 1ns / 1ps
package cafd_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_BOOK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   // Byte positions within a 40-byte group
   localparam logic [5:0] POS_HDR_END   = 6'd8;
   localparam logic [5:0] POS_A_BOOK    = 6'd8;
   localparam logic [5:0] POS_A_END     = 6'd23;
   localparam logic [5:0] POS_B_BOOK    = 6'd24;
   localparam logic [5:0] POS_GROUP_END = 6'd39;

   // Sample positions within a frame
   localparam logic [4:0] SAMPLE_FIRST_SUB = 5'd8;
   localparam logic [4:0] SAMPLE_LAST      = 5'd31;

   // Multiply-accumulate term kinds
   typedef enum logic [1:0] {
      TERM_X   = 2'd0,
      TERM_L1  = 2'd1,
      TERM_L2  = 2'd2,
      TERM_FIR = 2'd3
   } term_kind_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic          hdr_we;
      logic [2:0]    hdr_slot;
      logic          nib_we;
      logic [3:0]    nib_waddr;
      logic          term_valid;
      term_kind_type term_kind;
      logic          term_last;
      logic [3:0]    nib_raddr;
      logic          nib_lo;
      logic          latch;
      logic          emit_hdr;
      logic          frame_b;
      logic          hdr_sel;
      logic [3:0]    shift;
      logic          flag_last;
      logic          flag_done;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_busy;
      logic sample_done;
   } dp_status_type;

endpackage

/* rtl/cafd_ram.sv */
`timescale 1ns / 1ps
module cafd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cafd_ctrl.sv */
`timescale 1ns / 1ps
module cafd_ctrl #(
   parameter int BOOK_WORDS = 128,
   parameter int MAX_FRAMES = 16,
   localparam int AW = $clog2(BOOK_WORDS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  logic [6:0]             table_index,
   input  logic [4:0]             frame_count,
   input  logic                   start_second,
   input  logic [7:0]             data_byte,
   output logic                   book_we,
   output logic [AW-1:0]          coef_addr,
   output cafd_pkg::dp_cmd_type   cmd,
   input  cafd_pkg::dp_status_type status
);

   localparam int FW = $clog2(MAX_FRAMES + 1);
   localparam int NBOOKS = BOOK_WORDS / 16;

   typedef enum logic [5:0] {
      S_IN    = 6'b000001,
      S_BOOK  = 6'b000010,
      S_HDR   = 6'b000100,
      S_LATCH = 6'b001000,
      S_TERM  = 6'b010000,
      S_WAIT  = 6'b100000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic [5:0]    pos_ff, pos_in;
   logic [FW-1:0] frames_ff, frames_in;
   logic          skip_ff, skip_in;
   logic [3:0]    book_ff, book_in;
   logic [3:0]    shift_ff, shift_in;
   logic          frame_b_ff, frame_b_in;
   logic [4:0]    n_ff, n_in;
   logic [3:0]    t_ff, t_in;

   logic          accept;
   logic          data_acc;
   logic [2:0]    sub_i;
   logic [2:0]    fir_k;
   logic [4:0]    x_idx;
   logic [3:0]    coef_idx;
   cafd_pkg::term_kind_type kind_now;

   assign req_ready = (state_ff == S_IN);
   assign accept    = req_valid && req_ready;
   assign data_acc  = accept && (req_kind == cafd_pkg::KIND_DATA) && (frames_ff != '0);
   assign book_we   = accept && (req_kind == cafd_pkg::KIND_BOOK)
                      && (32'(table_index) < BOOK_WORDS);

   // Position within the sub-block and the filter tap of this term
   assign sub_i = (n_ff < cafd_pkg::SAMPLE_FIRST_SUB) ? 3'(n_ff - 5'd2) : n_ff[2:0];
   assign fir_k = 3'(t_ff - 4'd3);

   always_comb begin
      unique case (t_ff)
         4'd0:    kind_now = cafd_pkg::TERM_X;
         4'd1:    kind_now = cafd_pkg::TERM_L1;
         4'd2:    kind_now = cafd_pkg::TERM_L2;
         default: kind_now = cafd_pkg::TERM_FIR;
      endcase
   end

   // Residual index and book word for the current term
   always_comb begin
      x_idx    = n_ff;
      coef_idx = 4'd0;
      case (kind_now)
         cafd_pkg::TERM_L1:  coef_idx = {1'b0, sub_i};
         cafd_pkg::TERM_L2:  coef_idx = {1'b1, sub_i};
         cafd_pkg::TERM_FIR: begin
            coef_idx = {1'b1, fir_k};
            x_idx    = n_ff - 5'd1 - 5'(fir_k);
         end
         default: coef_idx = 4'd0;
      endcase
   end

   assign coef_addr = AW'({book_ff, 4'b0000}) + AW'(coef_idx);

   // Drive datapath commands
   always_comb begin
      cmd            = '0;
      cmd.hdr_we     = data_acc && (pos_ff < cafd_pkg::POS_HDR_END);
      cmd.hdr_slot   = pos_ff[2:0];
      cmd.nib_we     = data_acc && (pos_ff >= cafd_pkg::POS_HDR_END);
      cmd.nib_waddr  = (pos_ff < cafd_pkg::POS_B_BOOK) ? 4'(pos_ff - 6'd8)
                                                       : 4'(pos_ff - 6'd24);
      cmd.term_valid = (state_ff == S_TERM);
      cmd.term_kind  = kind_now;
      cmd.term_last  = (t_ff == 4'(sub_i) + 4'd2);
      cmd.nib_raddr  = x_idx[4:1];
      cmd.nib_lo     = x_idx[0];
      cmd.latch      = (state_ff == S_LATCH) && !status.out_busy && (sub_i == 3'd0);
      cmd.emit_hdr   = (state_ff == S_HDR) && !status.out_busy;
      cmd.frame_b    = frame_b_ff;
      cmd.hdr_sel    = n_ff[0];
      cmd.shift      = shift_ff;
      cmd.flag_last  = (n_ff == cafd_pkg::SAMPLE_LAST);
      cmd.flag_done  = (n_ff == cafd_pkg::SAMPLE_LAST) && (frames_ff == '0);
   end

   // Sequence input intake and frame decoding
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      frames_in  = frames_ff;
      skip_in    = skip_ff;
      book_in    = book_ff;
      shift_in   = shift_ff;
      frame_b_in = frame_b_ff;
      n_in       = n_ff;
      t_in       = t_ff;
      unique case (state_ff)
         S_IN: begin
            if (accept && (req_kind == cafd_pkg::KIND_START)) begin
               frames_in = (32'(frame_count) > MAX_FRAMES) ? FW'(MAX_FRAMES)
                                                           : FW'(frame_count);
               skip_in   = start_second;
               pos_in    = '0;
            end else if (data_acc) begin
               pos_in = (pos_ff == cafd_pkg::POS_GROUP_END) ? 6'd0 : pos_ff + 6'd1;
               if ((pos_ff == cafd_pkg::POS_A_BOOK) || (pos_ff == cafd_pkg::POS_B_BOOK)) begin
                  book_in  = data_byte[7:4];
                  shift_in = data_byte[3:0];
               end
               if (pos_ff == cafd_pkg::POS_A_END) begin
                  if (skip_ff) begin
                     skip_in = 1'b0;
                  end else begin
                     frames_in  = frames_ff - FW'(1);
                     frame_b_in = 1'b0;
                     state_in   = S_BOOK;
                  end
               end else if (pos_ff == cafd_pkg::POS_GROUP_END) begin
                  skip_in    = 1'b0;
                  frames_in  = frames_ff - FW'(1);
                  frame_b_in = 1'b1;
                  state_in   = S_BOOK;
               end
            end
         end
         S_BOOK: begin
            // Wrap the book number into the table
            if ({1'b0, book_ff} >= 5'(NBOOKS)) begin
               book_in = book_ff - 4'(NBOOKS);
            end else begin
               n_in     = 5'd0;
               state_in = S_HDR;
            end
         end
         S_HDR: begin
            if (!status.out_busy) begin
               if (n_ff[0]) begin
                  n_in     = 5'd2;
                  state_in = S_LATCH;
               end else begin
                  n_in = 5'd1;
               end
            end
         end
         S_LATCH: begin
            if (!status.out_busy) begin
               t_in     = 4'd0;
               state_in = S_TERM;
            end
         end
         S_TERM: begin
            if (cmd.term_last) begin
               state_in = S_WAIT;
            end else begin
               t_in = t_ff + 4'd1;
            end
         end
         S_WAIT: begin
            if (status.sample_done) begin
               if (n_ff == cafd_pkg::SAMPLE_LAST) begin
                  state_in = S_IN;
               end else begin
                  n_in     = n_ff + 5'd1;
                  state_in = S_LATCH;
               end
            end
         end
         default: state_in = S_IN;
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IN;
         pos_ff     <= '0;
         frames_ff  <= '0;
         skip_ff    <= 1'b0;
         book_ff    <= '0;
         shift_ff   <= '0;
         frame_b_ff <= 1'b0;
         n_ff       <= '0;
         t_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         frames_ff  <= frames_in;
         skip_ff    <= skip_in;
         book_ff    <= book_in;
         shift_ff   <= shift_in;
         frame_b_ff <= frame_b_in;
         n_ff       <= n_in;
         t_ff       <= t_in;
      end
   end

endmodule

/* rtl/cafd_dp.sv */
`timescale 1ns / 1ps
module cafd_dp #(
   parameter int BOOK_WORDS = 128,
   localparam int AW = $clog2(BOOK_WORDS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cafd_pkg::dp_cmd_type    cmd,
   output cafd_pkg::dp_status_type status,
   input  logic                    book_we,
   input  logic [6:0]              table_index,
   input  logic [15:0]             table_value,
   input  logic [AW-1:0]           coef_addr,
   input  logic [7:0]              data_byte,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [15:0]             out_sample,
   output logic                    out_last,
   output logic                    out_done
);

   logic [15:0] cb_rdata;
   logic [7:0]  nib_rdata;
   logic [7:0]  hbyte_ff [8];

   logic                    t1_valid_ff, t1_last_ff, t1_lo_ff;
   cafd_pkg::term_kind_type t1_kind_ff;
   logic                    p_valid_ff, p_last_ff, p_first_ff;
   logic signed [31:0]      prod_ff;
   logic signed [39:0]      acc_ff, acc_in;
   logic                    acc_last_ff;
   logic signed [15:0]      l1_ff, l2_ff, prev1_ff, prev2_ff;
   logic                    out_valid_ff, out_last_ff, out_done_ff;
   logic [15:0]             out_sample_ff;

   logic [3:0]         nib4;
   logic signed [15:0] resid, op_a, op_b, hdr_val, sat_val;
   logic signed [39:0] q;
   logic [15:0]        new_val;
   logic               load_out;

   cafd_ram #(.WIDTH(16), .DEPTH(BOOK_WORDS)) u_book (
      .clock   (clock),
      .wr_en   (book_we),
      .wr_addr (AW'(table_index)),
      .wr_data (table_value),
      .rd_addr (coef_addr),
      .rd_data (cb_rdata)
   );

   cafd_ram #(.WIDTH(8), .DEPTH(16)) u_nib (
      .clock   (clock),
      .wr_en   (cmd.nib_we),
      .wr_addr (cmd.nib_waddr),
      .wr_data (data_byte),
      .rd_addr (cmd.nib_raddr),
      .rd_data (nib_rdata)
   );

   // Capture header bytes
   always_ff @(posedge clock) begin
      if (cmd.hdr_we) begin
         hbyte_ff[cmd.hdr_slot] <= data_byte;
      end
   end

   always_comb begin
      case ({cmd.frame_b, cmd.hdr_sel})
         2'b00:   hdr_val = $signed({hbyte_ff[0], hbyte_ff[1]});
         2'b01:   hdr_val = $signed({hbyte_ff[2], hbyte_ff[3]});
         2'b10:   hdr_val = $signed({hbyte_ff[4], hbyte_ff[5]});
         default: hdr_val = $signed({hbyte_ff[6], hbyte_ff[7]});
      endcase
   end

   // Form the residual and the multiplier operands
   assign nib4  = t1_lo_ff ? nib_rdata[3:0] : nib_rdata[7:4];
   assign resid = $signed({nib4, 12'h000}) >>> cmd.shift;

   always_comb begin
      op_a = (t1_kind_ff == cafd_pkg::TERM_X) ? 16'sd2048 : $signed(cb_rdata);
      case (t1_kind_ff)
         cafd_pkg::TERM_L1: op_b = l1_ff;
         cafd_pkg::TERM_L2: op_b = l2_ff;
         default:           op_b = resid;
      endcase
   end

   // Accumulate, then floor-shift and saturate
   assign acc_in = (p_first_ff ? 40'sd0 : acc_ff) + 40'(prod_ff);
   assign q      = acc_ff >>> 11;

   always_comb begin
      if (q > 40'sd32767) begin
         sat_val = 16'sh7fff;
      end else if (q < -40'sd32768) begin
         sat_val = -16'sh8000;
      end else begin
         sat_val = 16'(q);
      end
   end

   assign load_out = cmd.emit_hdr || acc_last_ff;
   assign new_val  = cmd.emit_hdr ? hdr_val : sat_val;

   // Advance the MAC pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         p_valid_ff  <= 1'b0;
         acc_last_ff <= 1'b0;
      end else begin
         t1_valid_ff <= cmd.term_valid;
         p_valid_ff  <= t1_valid_ff;
         acc_last_ff <= p_valid_ff && p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_kind_ff <= cmd.term_kind;
      t1_last_ff <= cmd.term_last;
      t1_lo_ff   <= cmd.nib_lo;
      prod_ff    <= op_a * op_b;
      p_last_ff  <= t1_last_ff;
      p_first_ff <= (t1_kind_ff == cafd_pkg::TERM_X);
      if (p_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.latch) begin
         l1_ff <= prev2_ff;
         l2_ff <= prev1_ff;
      end
      if (load_out) begin
         prev2_ff      <= prev1_ff;
         prev1_ff      <= new_val;
         out_sample_ff <= new_val;
         out_last_ff   <= cmd.flag_last && !cmd.emit_hdr;
         out_done_ff   <= cmd.flag_done && !cmd.emit_hdr;
      end
   end

   // Hold the result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign out_valid          = out_valid_ff;
   assign out_sample         = out_sample_ff;
   assign out_last           = out_last_ff;
   assign out_done           = out_done_ff;
   assign status.out_busy    = out_valid_ff;
   assign status.sample_done = acc_last_ff;

endmodule

/* rtl/codebook_adpcm_frame_decoder.sv */
`timescale 1ns / 1ps
// Order-2 codebook ADPCM frame decoder. Codebook writes, start items and
// compressed bytes are taken one per cycle while no frame is being decoded.
// The byte that completes a frame (the 24th or 40th of a group) starts a
// decode; a skipped first frame starts none. During the decode req_tready
// stays low, also through any output stall. The book number is first wrapped
// into the table, then the two header samples are emitted. Each of the 30
// predicted samples then runs on the single shared multiply-accumulate unit:
// one wait for the previous sample's transfer, then one product a cycle from
// the codebook memory and the nibble memory, with one term more per position
// deeper into a sub-block, then the sum drains through the MAC pipeline.
// Each decoded frame emits 32 samples; rsp_tlast marks the 32nd, rsp_tuser
// marks the last sample of the last requested frame.
module codebook_adpcm_frame_decoder #(
   parameter int BOOK_WORDS = 128,
   parameter int MAX_FRAMES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // table_index[6:0], table_value[22:7], frame_count[27:23],
   // start_second[28], data_byte[36:29], zero fill[39:37]
   input  logic [39:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // sample[15:0]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   // stream_done[0]
   output logic        rsp_tuser
);

   localparam int AW = $clog2(BOOK_WORDS);

   cafd_pkg::dp_cmd_type    cmd;
   cafd_pkg::dp_status_type status;
   logic                    book_we;
   logic [AW-1:0]           coef_addr;

   cafd_ctrl #(.BOOK_WORDS(BOOK_WORDS), .MAX_FRAMES(MAX_FRAMES)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_kind     (req_tuser),
      .table_index  (req_tdata[6:0]),
      .frame_count  (req_tdata[27:23]),
      .start_second (req_tdata[28]),
      .data_byte    (req_tdata[36:29]),
      .book_we      (book_we),
      .coef_addr    (coef_addr),
      .cmd          (cmd),
      .status       (status)
   );

   cafd_dp #(.BOOK_WORDS(BOOK_WORDS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .book_we     (book_we),
      .table_index (req_tdata[6:0]),
      .table_value (req_tdata[22:7]),
      .coef_addr   (coef_addr),
      .data_byte   (req_tdata[36:29]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_sample  (rsp_tdata),
      .out_last    (rsp_tlast),
      .out_done    (rsp_tuser)
   );

   // A finished sum never lands on an occupied output register
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      status.sample_done |-> !status.out_busy)
      else $error("sample finished while output register busy");

   // No MAC term runs while input is being taken
   a_no_term_in_intake: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.term_valid)
      else $error("MAC term issued during intake");

   // Stream end is only flagged on the last sample of a frame
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("stream end without frame end");

endmodule

/* test/tb_codebook_adpcm_frame_decoder.sv */
`timescale 1ns / 1ps
module tb_codebook_adpcm_frame_decoder;

   localparam int BOOK_WORDS = 128;
   localparam int MAX_FRAMES = 16;
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct {
      logic [1:0]  kind;
      logic [6:0]  idx;
      logic [15:0] val;
      logic [4:0]  cnt;
      logic        sec;
      logic [7:0]  data;
   } req_item_type;

   typedef struct {
      logic [15:0] sample;
      logic        last;
      logic        done;
   } pcm_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   // Decoder shadow state
   logic [15:0] book_mem [BOOK_WORDS];
   logic [7:0]  grp_mem [24];
   int          grp_pos = 0;
   int          frames_left = 0;
   logic        skip_a = 1'b0;

   req_item_type pend_items[$];
   pcm_word_type pcm_expected[$];
   int          mismatches = 0;
   int          words_seen = 0;
   int          frames_seen = 0;
   int          items_sent = 0;
   int          in_gap = 0;
   int          out_gap = 0;
   bit          calm = 1'b0;

   codebook_adpcm_frame_decoder #(
      .BOOK_WORDS(BOOK_WORDS),
      .MAX_FRAMES(MAX_FRAMES)
   ) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // Pick an idle length: mostly none or short, a few long
   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Decode one frame from the group buffer and queue its 32 samples
   task automatic decode_frame(input int hdr);
      int          base;
      int          sh;
      int          st;
      int          sz;
      int          bk[16];
      longint      x[32];
      longint      y[32];
      longint      acc;
      logic [7:0]  v;
      logic signed [15:0] w;
      pcm_word_type pw;
      base = (int'(grp_mem[8][7:4]) % (BOOK_WORDS / 16)) * 16;
      sh = int'(grp_mem[8][3:0]);
      for (int j = 0; j < 16; j++) begin
         w = book_mem[(base + j) % BOOK_WORDS];
         bk[j] = w;
      end
      w = {grp_mem[hdr], grp_mem[hdr + 1]};
      y[0] = w;
      w = {grp_mem[hdr + 2], grp_mem[hdr + 3]};
      y[1] = w;
      for (int j = 1; j < 16; j++) begin
         v = grp_mem[8 + j];
         x[2 * j] = (longint'($signed(v[7:4])) * 4096) >>> sh;
         x[2 * j + 1] = (longint'($signed(v[3:0])) * 4096) >>> sh;
      end
      for (int b = 0; b < 4; b++) begin
         st = (b == 0) ? 2 : 8 * b;
         sz = (b == 0) ? 6 : 8;
         for (int i = 0; i < sz; i++) begin
            acc = x[st + i] * 2048 + longint'(bk[i]) * y[st - 2]
                  + longint'(bk[8 + i]) * y[st - 1];
            for (int k = 0; k < i; k++)
               acc += longint'(bk[8 + k]) * x[st + i - 1 - k];
            acc = acc >>> 11;
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            y[st + i] = acc;
         end
      end
      if (frames_left > 0) frames_left--;
      for (int j = 0; j < 32; j++) begin
         pw.sample = y[j][15:0];
         pw.last = (j == 31);
         pw.done = (j == 31) && (frames_left == 0);
         pcm_expected.push_back(pw);
      end
   endtask

   // Advance the shadow state by one accepted item
   task automatic apply_item(input req_item_type it);
      int pos;
      case (it.kind)
         cafd_pkg::KIND_BOOK: begin
            book_mem[it.idx] = it.val;
         end
         cafd_pkg::KIND_START: begin
            frames_left = (int'(it.cnt) > MAX_FRAMES) ? MAX_FRAMES : int'(it.cnt);
            skip_a = it.sec;
            grp_pos = 0;
         end
         cafd_pkg::KIND_DATA: begin
            if (frames_left != 0) begin
               pos = grp_pos;
               if (pos < 24) grp_mem[pos] = it.data;
               else grp_mem[pos - 16] = it.data;
               grp_pos = (pos >= 39) ? 0 : pos + 1;
               if (pos == 23) begin
                  if (skip_a) skip_a = 1'b0;
                  else decode_frame(0);
               end else if (pos == 39) begin
                  skip_a = 1'b0;
                  decode_frame(4);
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic req_item_type rand_item(input logic [1:0] kind);
      req_item_type it;
      it.kind = kind;
      it.idx = 7'($urandom);
      it.val = 16'($urandom);
      it.cnt = 5'($urandom);
      it.sec = 1'($urandom);
      it.data = 8'($urandom);
      return it;
   endfunction

   task automatic push_book(input int idx, input logic [15:0] val);
      req_item_type it;
      it = rand_item(cafd_pkg::KIND_BOOK);
      it.idx = 7'(idx);
      it.val = val;
      pend_items.push_back(it);
   endtask

   task automatic push_start(input int cnt, input bit sec);
      req_item_type it;
      it = rand_item(cafd_pkg::KIND_START);
      it.cnt = 5'(cnt);
      it.sec = sec;
      pend_items.push_back(it);
   endtask

   task automatic push_byte(input logic [7:0] b);
      req_item_type it;
      it = rand_item(cafd_pkg::KIND_DATA);
      it.data = b;
      pend_items.push_back(it);
   endtask

   // Bytes that cover a number of frame slots, groups split A then B
   function automatic int bytes_for(input int slots);
      return (slots / 2) * 40 + ((slots % 2) ? 24 : 0);
   endfunction

   // Queue a stream of random content; fill selects the byte pattern
   task automatic push_stream(input int cnt, input bit sec, input int nbytes,
                              input int fill);
      logic [7:0] b;
      push_start(cnt, sec);
      for (int i = 0; i < nbytes; i++) begin
         case (fill)
            1: b = 8'hff;
            2: b = 8'h00;
            3: b = ((i % 20) == 8 || (i % 40) == 24) ? 8'h00 : 8'h88;
            4: b = ((i % 40) < 8) ? ((i % 2) ? 8'hff : 8'h7f) : 8'h77;
            default: b = 8'($urandom);
         endcase
         push_byte(b);
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_item(pend_items.pop_front());
            items_sent++;
            if ($urandom_range(0, 60) == 0) calm = ~calm;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (in_gap > 0) begin
               in_gap--;
               req_tvalid <= 1'b0;
            end else if (pend_items.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser <= pend_items[0].kind;
               req_tdata <= {3'b000, pend_items[0].data, pend_items[0].sec,
                             pend_items[0].cnt, pend_items[0].val, pend_items[0].idx};
               in_gap = pick_gap(calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (out_gap > 0) begin
            out_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            out_gap = ($urandom_range(0, 3) == 0) ? pick_gap(calm) : 0;
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      pcm_word_type pw;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (rsp_tlast) frames_seen++;
         if (pcm_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected sample %h last %b done %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            pw = pcm_expected.pop_front();
            if (pw.sample !== rsp_tdata || pw.last !== rsp_tlast
                || pw.done !== rsp_tuser) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("sample %0d: expected %h/%b/%b, got %h/%b/%b",
                           words_seen, pw.sample, pw.last, pw.done,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int n;
      int cnt;
      bit sec;
      int r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Load the whole codebook so every book read hits a written word
      for (int i = 0; i < BOOK_WORDS; i++) push_book(i, 16'($urandom));

      // Directed: extreme coefficients, extreme bytes, skip, restart, noise
      push_book(0, 16'h7fff);
      push_book(9, 16'h8000);
      push_book(127, 16'h8000);
      pend_items.push_back(rand_item(KIND_NONE));
      push_start(0, 1'b0);
      push_byte(8'hff);
      push_stream(1, 1'b0, 24, 1);
      push_stream(2, 1'b0, 40, 2);
      push_stream(2, 1'b0, 40, 3);
      push_stream(1, 1'b1, 40, 4);
      push_stream(3, 1'b0, 10, 0);
      push_stream(1, 1'b0, 30, 0);

      // Random: mostly well-formed streams, some cut short or overrun
      n = 0;
      while (n < 80) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            push_book($urandom_range(0, BOOK_WORDS - 1), 16'($urandom));
            n++;
         end else if (r < 11) begin
            pend_items.push_back(rand_item(KIND_NONE));
         end else begin
            cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31)
                                               : $urandom_range(1, 3);
            sec = 1'($urandom);
            r = bytes_for(((cnt > MAX_FRAMES) ? MAX_FRAMES : cnt) + int'(sec));
            if ($urandom_range(0, 9) == 0) r = $urandom_range(0, r);
            else if ($urandom_range(0, 9) == 0) r += $urandom_range(1, 30);
            push_stream(cnt, sec, r, ($urandom_range(0, 15) == 0) ? 4 : 0);
            n += r + 1;
         end
      end

      wait (pend_items.size() == 0 && !req_tvalid);
      wait (pcm_expected.size() == 0);
      repeat (500) @(posedge clock);
      $display("sent %0d request items, checked %0d samples in %0d frames",
               items_sent, words_seen, frames_seen);
      $display("%0d mismatches, %0d samples still pending",
               mismatches, pcm_expected.size());
      if (mismatches == 0 && pcm_expected.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("timeout with %0d samples pending", pcm_expected.size());
      $display("status: fail");
      $finish;
   end

endmodule

/* files.f */
rtl/cafd_pkg.sv
rtl/cafd_ram.sv
rtl/cafd_ctrl.sv
rtl/cafd_dp.sv
rtl/codebook_adpcm_frame_decoder.sv
test/tb_codebook_adpcm_frame_decoder.sv
